// ===== rtl/serial_read_slave_with_checksum_macros.svh =====
// Assertion macros shared by the serial read slave RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef SERIAL_READ_SLAVE_WITH_CHECKSUM_MACROS_SVH
`define SERIAL_READ_SLAVE_WITH_CHECKSUM_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset
`define SRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srs_pkg.sv =====
// Package for the serial read slave: payload types, cell controls and constants.
// Depends on nothing.
package srs_pkg;

    localparam int unsigned FRAME_BITS = 16;
    localparam int unsigned REPLY_BITS = 40;
    localparam int unsigned COUNT_BITS = 6;

    localparam logic [FRAME_BITS-1:0] READ_FRAME = 16'hCC01;
    localparam logic [COUNT_BITS-1:0] REPLY_LAST = 6'd40;

    // One bus edge
    typedef struct packed {
        logic        data_in;
        logic [31:0] measured_value;
    } item_t;

    // Line state after that edge
    typedef struct packed {
        logic out_bit;
        logic sending;
    } result_t;

    // Per-cell control: parallel load wins over shift
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/srs_stream_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// Depends on nothing; the payload type is set where the channel is declared.
interface srs_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/serial_read_slave_with_checksum.sv =====
// Top level of the serial read slave: frame and reply chains, control, result stage.
// Depends on srs_pkg, srs_stream_if, srs_chain and the assertion macros header.
//
// Usage
//   item   : one transfer per bus clock edge, carrying the input line level
//            (data_in) and the live 32-bit measurement (measured_value).
//   result : exactly one transfer per item, giving the output line level
//            (out_bit) and whether a reply is in progress (sending).
//   While idle each input bit enters a 16-bit frame chain. When the chain
//   reads 0xCC01 the measurement and an 8-bit byte-sum checksum load into a
//   40-cell reply chain; the next 40 items each shift one reply bit, MSB
//   first, onto out_bit, and the 41st item returns the block to idle.
//   Output: the result of an item is registered and presented the cycle after its transfer.
//   Throughput: one item per cycle while not stalled; every cell updates in the same cycle and
//   the result register frees as soon as the receiver takes its transfer.
//   Stall: item.ready falls only while a result waits and result.ready is low.
//   Reset: all chain cells clear, the line idles high, no result is pending.
`include "serial_read_slave_with_checksum_macros.svh"

module serial_read_slave_with_checksum
(
    input  logic         clk,
    input  logic         rst_n,
    srs_stream_if.sink   item,
    srs_stream_if.source result
);

    localparam int unsigned FB = srs_pkg::FRAME_BITS;
    localparam int unsigned RB = srs_pkg::REPLY_BITS;
    localparam int unsigned CB = srs_pkg::COUNT_BITS;

    logic                take;
    logic                data_in;
    logic [31:0]         meas;
    logic [FB-1:0]       frame_q;
    logic [RB-1:0]       reply_q;
    logic [7:0]          checksum;
    logic                match;
    logic                send_shift;
    srs_pkg::cell_ctrl_t frame_ctrl;
    srs_pkg::cell_ctrl_t reply_ctrl;

    logic                send_active_reg;
    logic                send_active_next;
    logic [CB-1:0]       bit_count_reg;
    logic [CB-1:0]       bit_count_next;
    logic                out_level_reg;
    logic                out_level_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    srs_pkg::result_t    out_data_reg;

    // Handshake: accept whenever the result stage is free or being drained
    assign item.ready = !out_valid_reg || result.ready;
    assign take       = item.valid && item.ready;
    assign data_in    = item.payload.data_in;
    assign meas       = item.payload.measured_value;

    // Frame match on the value the chain takes at this edge
    assign match = !send_active_reg && ({frame_q[FB-2:0], data_in} == srs_pkg::READ_FRAME);

    // Wrapping sum of the four measurement bytes
    assign checksum = meas[31:24] + meas[23:16] + meas[15:8] + meas[7:0];

    assign send_shift = send_active_reg && (bit_count_reg != srs_pkg::REPLY_LAST);

    // Cell controls
    always_comb
    begin
        frame_ctrl.load  = 1'b0;
        frame_ctrl.shift = take && !send_active_reg;
        reply_ctrl.load  = take && match;
        reply_ctrl.shift = take && send_shift;
    end

    srs_chain #(.WIDTH(FB)) u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (frame_ctrl),
        .load_data ({FB{1'b0}}),
        .serial_in (data_in),
        .q         (frame_q)
    );

    srs_chain #(.WIDTH(RB)) u_reply
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (reply_ctrl),
        .load_data ({meas, checksum}),
        .serial_in (1'b0),
        .q         (reply_q)
    );

    // Send control and line level
    always_comb
    begin
        send_active_next = send_active_reg;
        bit_count_next   = bit_count_reg;
        out_level_next   = out_level_reg;
        if (take)
        begin
            priority if (!send_active_reg)
            begin
                if (match)
                begin
                    send_active_next = 1'b1;
                    bit_count_next   = '0;
                end
            end
            else if (send_shift)
            begin
                out_level_next = reply_q[RB-1];
                bit_count_next = bit_count_reg + 1'b1;
            end
            else
            begin
                send_active_next = 1'b0;
                bit_count_next   = '0;
            end
        end
    end

    // Result stage valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_active_reg <= 1'b0;
            bit_count_reg   <= '0;
            out_level_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            send_active_reg <= send_active_next;
            bit_count_reg   <= bit_count_next;
            out_level_reg   <= out_level_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg.out_bit <= out_level_next;
            out_data_reg.sending <= send_active_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    // Checks
    `SRS_ASSERT_NOW(a_count_range, 1'b1, bit_count_reg <= srs_pkg::REPLY_LAST,
        "reply bit count beyond reply length")
    `SRS_ASSERT_NOW(a_idle_count, !send_active_reg, bit_count_reg == '0,
        "bit count non-zero while idle")
    `SRS_ASSERT_NEXT(a_match_starts, take && match,
        send_active_reg && bit_count_reg == '0 && result.payload.sending,
        "matching frame did not start a reply")
    `SRS_ASSERT_NEXT(a_shift_level, take && send_shift,
        out_level_reg == $past(reply_q[RB-1]),
        "line level does not follow reply MSB")

endmodule

// ===== rtl/srs_cell.sv =====
// One bit of a shift chain: parallel load, shift from the neighbour, or hold.
// Depends on srs_pkg.
module srs_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  srs_pkg::cell_ctrl_t ctrl,
    input  logic                load_bit,
    input  logic                shift_bit,
    output logic                q
);

    logic q_reg;
    logic q_next;

    // Load takes priority over shift
    always_comb
    begin
        priority if (ctrl.load)
        begin
            q_next = load_bit;
        end
        else if (ctrl.shift)
        begin
            q_next = shift_bit;
        end
        else
        begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/srs_chain.sv =====
// Row of srs_cell bits shifting towards the MSB, serial input at bit 0.
// Depends on srs_pkg and srs_cell.
module srs_chain #(
    parameter int unsigned WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  srs_pkg::cell_ctrl_t ctrl,
    input  logic [WIDTH-1:0]    load_data,
    input  logic                serial_in,
    output logic [WIDTH-1:0]    q
);

    logic [WIDTH-1:0] neighbour;

    // Each cell takes the bit below it; the bottom cell takes the serial input
    assign neighbour = {q[WIDTH-2:0], serial_in};

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        srs_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .load_bit  (load_data[i]),
            .shift_bit (neighbour[i]),
            .q         (q[i])
        );
    end

endmodule

// ===== tb/serial_read_slave_with_checksum_tb.sv =====
// Self-checking testbench for serial_read_slave_with_checksum: a directed table, then
// random reads and noise; results checked against a bit-level predictor or typed rows.
// Depends on srs_pkg, srs_stream_if and the top-level RTL.
module serial_read_slave_with_checksum_tb;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned HOLD_AT      = 500;   // items sent before the long hold-off
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned IDLE_LIMIT   = 5000;  // cycles with no transfer at all
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned REPORT_MAX   = 10;

    // Line levels that can be read straight off the frame and reply bits
    localparam srs_pkg::result_t IDLE_HIGH = '{out_bit: 1'b1, sending: 1'b0};
    localparam srs_pkg::result_t IDLE_LOW  = '{out_bit: 1'b0, sending: 1'b0};
    localparam srs_pkg::result_t SEND_HIGH = '{out_bit: 1'b1, sending: 1'b1};
    localparam srs_pkg::result_t SEND_LOW  = '{out_bit: 1'b0, sending: 1'b1};

    typedef struct packed {
        logic             data_in;
        logic [31:0]      meas;
        logic [7:0]       reps;
        logic             typed;   // check against want rather than the predictor
        srs_pkg::result_t want;
    } stim_row_t;

    // Directed stimulus: a read of all ones, a near-miss frame, then a second full read
    // whose byte-sum checksum wraps
    localparam int unsigned STIM_ROWS = 24;
    localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
        '{1'b0, 32'h0000_0000,  8'd1, 1'b1, IDLE_HIGH},  // first edge after reset
        '{1'b1, 32'hFFFF_FFFF,  8'd2, 1'b1, IDLE_HIGH},  // 0xCC01, MSB first
        '{1'b0, 32'h0000_0000,  8'd2, 1'b1, IDLE_HIGH},
        '{1'b1, 32'hFFFF_FFFF,  8'd2, 1'b1, IDLE_HIGH},
        '{1'b0, 32'h0000_0000,  8'd9, 1'b1, IDLE_HIGH},
        '{1'b1, 32'hFFFF_FFFF,  8'd1, 1'b1, SEND_HIGH},  // matching edge: capture only
        '{1'b0, 32'h0000_0000, 8'd32, 1'b1, SEND_HIGH},  // measurement, input ignored
        '{1'b1, 32'h0000_0000,  8'd6, 1'b1, SEND_HIGH},  // checksum 0xFC
        '{1'b1, 32'h0000_0000,  8'd2, 1'b1, SEND_LOW},
        '{1'b1, 32'h0000_0000,  8'd1, 1'b1, IDLE_LOW},   // final edge keeps last bit
        '{1'b1, 32'h0000_FFFF,  8'd2, 1'b1, IDLE_LOW},   // 0xCD01: wrong header byte
        '{1'b0, 32'hFFFF_0000,  8'd2, 1'b1, IDLE_LOW},
        '{1'b1, 32'h0000_0000,  8'd2, 1'b1, IDLE_LOW},
        '{1'b0, 32'h0000_0000,  8'd1, 1'b1, IDLE_LOW},
        '{1'b1, 32'h0000_0000,  8'd1, 1'b1, IDLE_LOW},
        '{1'b0, 32'h0000_0000,  8'd7, 1'b1, IDLE_LOW},
        '{1'b1, 32'h0000_0000,  8'd1, 1'b1, IDLE_LOW},
        '{1'b1, 32'hA5A5_A5A5,  8'd2, 1'b1, IDLE_LOW},   // 0xCC01 again
        '{1'b0, 32'h5A5A_5A5A,  8'd2, 1'b1, IDLE_LOW},
        '{1'b1, 32'hA5A5_A5A5,  8'd2, 1'b1, IDLE_LOW},
        '{1'b0, 32'h5A5A_5A5A,  8'd9, 1'b1, IDLE_LOW},
        '{1'b1, 32'h80FF_0001,  8'd1, 1'b1, SEND_LOW},
        '{1'b0, 32'h1234_5678, 8'd41, 1'b0, IDLE_LOW},   // reply with wrapped checksum
        '{1'b1, 32'hFFFF_FFFF,  8'd3, 1'b0, IDLE_LOW}    // shifting resumes after reply
    };

    logic clk;
    logic rst_n;

    srs_stream_if #(.payload_t(srs_pkg::item_t))   item_ch ();
    srs_stream_if #(.payload_t(srs_pkg::result_t)) line_ch ();

    serial_read_slave_with_checksum u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (line_ch)
    );

    // Predictor state
    logic [srs_pkg::FRAME_BITS-1:0] frame_bits  = '0;
    logic                           reply_busy  = 1'b0;
    logic [srs_pkg::REPLY_BITS-1:0] reply_bits  = '0;
    logic [srs_pkg::COUNT_BITS-1:0] reply_sent  = '0;
    logic                           line_level  = 1'b1;

    srs_pkg::result_t pending_lines [$];
    int unsigned      fail_count  = 0;
    int unsigned      items_sent  = 0;
    int unsigned      idle_cycles = 0;
    bit               calm        = 1'b0;   // new gaps and stalls are drawn as zero while set
    bit               hold_done   = 1'b0;
    bit               typed_now   = 1'b0;
    srs_pkg::result_t typed_line  = '0;

    // Line state after one bus edge; advances the predictor
    function automatic srs_pkg::result_t predict_line(srs_pkg::item_t edge_in);
        srs_pkg::result_t line;
        logic [7:0]       csum;
        if (!reply_busy) begin
            frame_bits = {frame_bits[srs_pkg::FRAME_BITS-2:0], edge_in.data_in};
            if (frame_bits == srs_pkg::READ_FRAME) begin
                csum = edge_in.measured_value[31:24] + edge_in.measured_value[23:16]
                     + edge_in.measured_value[15:8] + edge_in.measured_value[7:0];
                reply_bits = {edge_in.measured_value, csum};
                reply_sent = '0;
                reply_busy = 1'b1;
            end
        end else if (reply_sent < srs_pkg::REPLY_LAST) begin
            line_level = reply_bits[srs_pkg::REPLY_BITS-1];
            reply_bits = reply_bits << 1;
            reply_sent = reply_sent + 1'b1;
        end else begin
            reply_sent = '0;
            reply_busy = 1'b0;
        end
        line.out_bit = line_level;
        line.sending = reply_busy;
        return line;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_meas();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 32'h0000_0000;
        if (roll == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", what);
    endtask

    // One item transfer, preceded by a random gap; returns at the following falling edge
    task automatic offer(input logic din, input logic [31:0] meas,
                         input bit typed, input srs_pkg::result_t want);
        int unsigned    gap;
        srs_pkg::item_t edge_out;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        typed_now  = typed;
        typed_line = want;
        edge_out.data_in        = din;
        edge_out.measured_value = meas;
        item_ch.valid   <= 1'b1;
        item_ch.payload <= edge_out;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        int unsigned stall;
        stall = 0;
        line_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                line_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall > 0)
            begin
                line_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap();
                line_ch.ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    // Monitor: predict on item transfers, check on result transfers
    always @(posedge clk)
    begin
        srs_pkg::result_t want;
        bit               moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (line_ch.valid && line_ch.ready)
            begin
                moved = 1'b1;
                if (pending_lines.size() == 0)
                    note_failure($sformatf("unexpected result: out_bit=%0b sending=%0b",
                                           line_ch.payload.out_bit,
                                           line_ch.payload.sending));
                else
                begin
                    want = pending_lines.pop_front();
                    if (line_ch.payload.out_bit !== want.out_bit ||
                        line_ch.payload.sending !== want.sending)
                        note_failure($sformatf(
                            "mismatch: out_bit exp %0b got %0b, sending exp %0b got %0b",
                            want.out_bit, line_ch.payload.out_bit,
                            want.sending, line_ch.payload.sending));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                moved = 1'b1;
                want = predict_line(item_ch.payload);
                if (typed_now)
                    want = typed_line;
                pending_lines.push_back(want);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus
    initial
    begin
        int                             r;
        int                             n;
        int                             b;
        int unsigned                    kind;
        int unsigned                    dir_items;
        logic [srs_pkg::FRAME_BITS-1:0] near_frame;

        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (r = 0; r < STIM_ROWS; r++)
            for (n = 0; n < STIM_TABLE[r].reps; n++)
                offer(STIM_TABLE[r].data_in, STIM_TABLE[r].meas,
                      STIM_TABLE[r].typed, STIM_TABLE[r].want);
        dir_items = items_sent;

        // Random: mostly complete reads with random content, the rest near misses and noise
        while (items_sent - dir_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                repeat ($urandom_range(0, 3))
                    offer(1'($urandom_range(0, 1)), pick_meas(), 1'b0, '0);
                for (b = srs_pkg::FRAME_BITS - 1; b >= 0; b--)
                    offer(srs_pkg::READ_FRAME[b], pick_meas(), 1'b0, '0);
                repeat (srs_pkg::REPLY_BITS + 1)
                    offer(1'($urandom_range(0, 1)), pick_meas(), 1'b0, '0);
            end
            else if (kind < 9)
            begin
                // read frame with one bit flipped
                near_frame = srs_pkg::READ_FRAME
                           ^ (16'h0001 << $urandom_range(0, srs_pkg::FRAME_BITS - 1));
                for (b = srs_pkg::FRAME_BITS - 1; b >= 0; b--)
                    offer(near_frame[b], pick_meas(), 1'b0, '0);
            end
            else
                repeat ($urandom_range(1, 24))
                    offer(1'($urandom_range(0, 1)), pick_meas(), 1'b0, '0);
        end
        item_ch.valid <= 1'b0;

        // Drain
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_lines.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_lines.size()));

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srs_pkg.sv
rtl/srs_stream_if.sv
rtl/srs_cell.sv
rtl/srs_chain.sv
rtl/serial_read_slave_with_checksum.sv
tb/serial_read_slave_with_checksum_tb.sv
